// File: rtl/core/ehdc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the day-of-year split for the holy-day calculator.
// No dependencies; used by ehdc_ctrl and easter_holy_day_calculator.
package ehdc_pkg;

  // Pipeline depth: one stage per register rank of the datapath.
  localparam int NUM_STAGES = 10;

  // Reciprocal multipliers for division by constants: q = (x * MUL) >> SHIFT.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;   // applied to year >> 2
  localparam int          DIV100_SHIFT = 17;
  localparam logic [15:0] DIV19_MUL    = 16'd55189;
  localparam int          DIV19_SHIFT  = 20;
  localparam logic [9:0]  DIV25_MUL    = 10'd656;
  localparam int          DIV25_SHIFT  = 14;
  localparam logic [9:0]  DIV3_MUL     = 10'd683;
  localparam int          DIV3_SHIFT   = 11;
  localparam logic [10:0] DIV30_MUL    = 11'd1093;
  localparam int          DIV30_SHIFT  = 15;
  localparam logic [5:0]  DIV7_MUL     = 6'd37;
  localparam int          DIV7_SHIFT   = 8;

  // Computus constants.
  localparam logic [9:0] CENT_BIAS = 10'd8;
  localparam logic [9:0] H_BIAS    = 10'd15;
  localparam logic [6:0] L_BIAS    = 7'd32;
  localparam logic [8:0] M_LIMIT   = 9'd451;
  // 114 - 93 + 59: zero-based day of year of Easter relative to h + l - 7m.
  localparam logic [7:0] EDOY_BIAS = 8'd80;

  // Feast offsets from Easter, in days.
  localparam logic [7:0] CARN_OFS = 8'd49;
  localparam logic [7:0] GF_OFS   = 8'd2;
  localparam logic [7:0] ASC_OFS  = 8'd39;
  localparam logic [7:0] WHIT_OFS = 8'd49;

  // Zero-based first day of each month in a common year.
  localparam logic [7:0] START_FEB = 8'd31;
  localparam logic [7:0] START_MAR = 8'd59;
  localparam logic [7:0] START_APR = 8'd90;
  localparam logic [7:0] START_MAY = 8'd120;
  localparam logic [7:0] START_JUN = 8'd151;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;   // stage loads this cycle
    logic [NUM_STAGES-1:0] vld;  // stage holds a live beat
  } pipe_ctrl_t;

  typedef struct packed {
    logic [2:0] month;
    logic [4:0] day;
  } month_day_t;

  // Split a zero-based day of year (January..June) into month and day.
  function automatic month_day_t split_doy(logic [7:0] doy, logic leap);
    month_day_t md;
    logic [7:0] lp;
    logic [7:0] start;
    lp = {7'd0, leap};
    if (doy >= START_JUN + lp) begin
      md.month = 3'd6;
      start    = START_JUN + lp;
    end else if (doy >= START_MAY + lp) begin
      md.month = 3'd5;
      start    = START_MAY + lp;
    end else if (doy >= START_APR + lp) begin
      md.month = 3'd4;
      start    = START_APR + lp;
    end else if (doy >= START_MAR + lp) begin
      md.month = 3'd3;
      start    = START_MAR + lp;
    end else if (doy >= START_FEB) begin
      md.month = 3'd2;
      start    = START_FEB;
    end else begin
      md.month = 3'd1;
      start    = 8'd0;
    end
    md.day = 5'(doy - start + 8'd1);
    return md;
  endfunction

endpackage

// File: rtl/core/ehdc_ctrl.sv
`timescale 1ns / 1ps
// Valid tracking and per-stage load enables for the calculator pipeline.
// Depends on ehdc_pkg.
module ehdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_stall,
  output logic                in_stall,
  output ehdc_pkg::pipe_ctrl_t pc
);
  import ehdc_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES:0]   ready;

  // A stage may load when it is empty or its successor loads too.
  always_comb begin
    ready[NUM_STAGES] = !out_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      ready[k] = !vld_r[k] || ready[k+1];
    end
  end

  always_comb begin
    if (ready[0]) begin
      vld_nxt[0] = in_valid;
    end else begin
      vld_nxt[0] = vld_r[0];
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ready[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !ready[0];
  assign pc.en    = ready[NUM_STAGES-1:0];
  assign pc.vld   = vld_r;

`ifndef SYNTHESIS
  // Input back-pressure only when every stage is full and the output is held.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("input stalled while pipeline has room");

  // An accepted beat lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted beat lost at pipeline entry");

  // A held result stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NUM_STAGES-1] && out_stall) |=> vld_r[NUM_STAGES-1])
    else $error("stalled result dropped");

  // With the output free, the last stage follows its predecessor.
  a_last_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |=> (vld_r[NUM_STAGES-1] == $past(vld_r[NUM_STAGES-2])))
    else $error("last stage did not advance");
`endif

endmodule

// File: rtl/core/easter_holy_day_calculator.sv
`timescale 1ns / 1ps
// Top level: ten-stage computus pipeline and month/day split for five feasts.
// Depends on ehdc_pkg and ehdc_ctrl.
//
// Takes one Gregorian year per beat and returns Easter, Carnival (-49 days),
// Good Friday (-2), Ascension (+39) and Whitsuntide (+49) as month/day pairs.
// Throughput is one year per clock while the output is not stalled; each year
// passes through ten register stages of the computus datapath (reciprocal
// multiplies for the constant divisions, each followed by a register). Stalls
// ripple back stage by stage, so empty slots are filled while a result waits at
// the output. No state is kept between years and there is no configuration.
module easter_holy_day_calculator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_easter_month,
  output logic [4:0]  out_easter_day,
  output logic [1:0]  out_carnival_month,
  output logic [4:0]  out_carnival_day,
  output logic [2:0]  out_good_friday_month,
  output logic [4:0]  out_good_friday_day,
  output logic [2:0]  out_ascension_month,
  output logic [4:0]  out_ascension_day,
  output logic [2:0]  out_whitsun_month,
  output logic [4:0]  out_whitsun_day
);
  import ehdc_pkg::*;

  pipe_ctrl_t pc;

  ehdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .pc        (pc)
  );

  // ---------------- stage 0: year / 100 and year / 19 ----------------
  logic [26:0] b_prod;
  logic [31:0] q19_prod;
  logic [15:0] y0_r;
  logic [9:0]  b0_r, b0_nxt;
  logic [11:0] q19_0_r, q19_0_nxt;

  always_comb begin
    b_prod    = 27'(in_year[15:2]) * 27'(DIV100_MUL);
    q19_prod  = 32'(in_year) * 32'(DIV19_MUL);
    b0_nxt    = b_prod[DIV100_SHIFT +: 10];
    q19_0_nxt = q19_prod[DIV19_SHIFT +: 12];
  end

  always_ff @(posedge clk) begin
    if (pc.en[0]) begin
      y0_r    <= in_year;
      b0_r    <= b0_nxt;
      q19_0_r <= q19_0_nxt;
    end
  end

  // stage 1: remainders a and c, quotient f
  logic [15:0] c_wide, a_wide;
  logic [9:0]  bf;
  logic [19:0] f_prod;
  logic [4:0]  a1_r, a1_nxt;
  logic [6:0]  c1_r, c1_nxt;
  logic [9:0]  b1_r;
  logic [4:0]  f1_r, f1_nxt;

  always_comb begin
    c_wide = y0_r - 16'(b0_r) * 16'd100;
    a_wide = y0_r - 16'(q19_0_r) * 16'd19;
    bf     = b0_r + CENT_BIAS;
    f_prod = 20'(bf) * 20'(DIV25_MUL);
    c1_nxt = c_wide[6:0];
    a1_nxt = a_wide[4:0];
    f1_nxt = f_prod[DIV25_SHIFT +: 5];
  end

  always_ff @(posedge clk) begin
    if (pc.en[1]) begin
      a1_r <= a1_nxt;
      c1_r <= c1_nxt;
      b1_r <= b0_r;
      f1_r <= f1_nxt;
    end
  end

  // ---------------- stage 2: g, partial h sum, leap ----------------
  logic [9:0]  gx;
  logic [19:0] g_prod;
  logic [7:0]  g2_r, g2_nxt;
  logic [9:0]  hs2_r, hs2_nxt;
  logic [4:0]  a2_r;
  logic [1:0]  e2_r;
  logic [6:0]  c2_r;
  logic        leap2_r, leap2_nxt;

  always_comb begin
    gx        = b1_r - 10'(f1_r) + 10'd1;
    g_prod    = 20'(gx) * 20'(DIV3_MUL);
    g2_nxt    = g_prod[DIV3_SHIFT +: 8];
    hs2_nxt   = 10'(a1_r) * 10'd19 + b1_r - {2'd0, b1_r[9:2]} + H_BIAS;
    // divisible by 4, and a century only when divisible by 400
    leap2_nxt = (c1_r[1:0] == 2'd0) && !((c1_r == 7'd0) && (b1_r[1:0] != 2'd0));
  end

  always_ff @(posedge clk) begin
    if (pc.en[2]) begin
      g2_r    <= g2_nxt;
      hs2_r   <= hs2_nxt;
      a2_r    <= a1_r;
      e2_r    <= b1_r[1:0];
      c2_r    <= c1_r;
      leap2_r <= leap2_nxt;
    end
  end

  // ---------------- stage 3: h sum and its quotient by 30 ----------------
  logic [9:0]  hsum;
  logic [20:0] q30_prod;
  logic [9:0]  hsum3_r;
  logic [5:0]  q30_3_r, q30_3_nxt;
  logic [4:0]  a3_r;
  logic [1:0]  e3_r;
  logic [6:0]  c3_r;
  logic        leap3_r;

  always_comb begin
    hsum      = hs2_r - 10'(g2_r);
    q30_prod  = 21'(hsum) * 21'(DIV30_MUL);
    q30_3_nxt = q30_prod[DIV30_SHIFT +: 6];
  end

  always_ff @(posedge clk) begin
    if (pc.en[3]) begin
      hsum3_r <= hsum;
      q30_3_r <= q30_3_nxt;
      a3_r    <= a2_r;
      e3_r    <= e2_r;
      c3_r    <= c2_r;
      leap3_r <= leap2_r;
    end
  end

  // ---------------- stage 4: h ----------------
  logic [9:0] h_wide;
  logic [4:0] h4_r;
  logic [4:0] a4_r;
  logic [1:0] e4_r;
  logic [6:0] c4_r;
  logic       leap4_r;

  assign h_wide = hsum3_r - 10'(q30_3_r) * 10'd30;

  always_ff @(posedge clk) begin
    if (pc.en[4]) begin
      h4_r    <= h_wide[4:0];
      a4_r    <= a3_r;
      e4_r    <= e3_r;
      c4_r    <= c3_r;
      leap4_r <= leap3_r;
    end
  end

  // ---------------- stage 5: l sum and its quotient by 7 ----------------
  logic [6:0]  lsum;
  logic [12:0] q7_prod;
  logic [6:0]  lsum5_r;
  logic [3:0]  q7_5_r;
  logic [4:0]  h5_r;
  logic [4:0]  a5_r;
  logic        leap5_r;

  always_comb begin
    lsum    = L_BIAS + {4'd0, e4_r, 1'b0} + {1'b0, c4_r[6:2], 1'b0}
              - {2'd0, h4_r} - {5'd0, c4_r[1:0]};
    q7_prod = 13'(lsum) * 13'(DIV7_MUL);
  end

  always_ff @(posedge clk) begin
    if (pc.en[5]) begin
      lsum5_r <= lsum;
      q7_5_r  <= q7_prod[DIV7_SHIFT +: 4];
      h5_r    <= h4_r;
      a5_r    <= a4_r;
      leap5_r <= leap4_r;
    end
  end

  // ---------------- stage 6: l ----------------
  logic [6:0] l_wide;
  logic [2:0] l6_r;
  logic [4:0] h6_r;
  logic [4:0] a6_r;
  logic       leap6_r;

  assign l_wide = lsum5_r - 7'(q7_5_r) * 7'd7;

  always_ff @(posedge clk) begin
    if (pc.en[6]) begin
      l6_r    <= l_wide[2:0];
      h6_r    <= h5_r;
      a6_r    <= a5_r;
      leap6_r <= leap5_r;
    end
  end

  // ---------------- stage 7: m ----------------
  logic [8:0] msum;
  logic       m7_r;
  logic [2:0] l7_r;
  logic [4:0] h7_r;
  logic       leap7_r;

  // msum stays below 902, so the quotient by 451 is a single compare
  assign msum = 9'(a6_r) + 9'(h6_r) * 9'd11 + 9'(l6_r) * 9'd22;

  always_ff @(posedge clk) begin
    if (pc.en[7]) begin
      m7_r    <= (msum >= M_LIMIT);
      l7_r    <= l6_r;
      h7_r    <= h6_r;
      leap7_r <= leap6_r;
    end
  end

  // ---------------- stage 8: day numbers of the five feasts ----------------
  logic [7:0] edoy;
  logic [7:0] easter8_r, carn8_r, gf8_r, asc8_r, whit8_r;
  logic       leap8_r;

  assign edoy = 8'(h7_r) + 8'(l7_r) + EDOY_BIAS + 8'(leap7_r) - (m7_r ? 8'd7 : 8'd0);

  always_ff @(posedge clk) begin
    if (pc.en[8]) begin
      easter8_r <= edoy;
      carn8_r   <= edoy - CARN_OFS;
      gf8_r     <= edoy - GF_OFS;
      asc8_r    <= edoy + ASC_OFS;
      whit8_r   <= edoy + WHIT_OFS;
      leap8_r   <= leap7_r;
    end
  end

  // ---------------- stage 9: month/day split, output register ----------------
  month_day_t easter_md, carn_md, gf_md, asc_md, whit_md;
  month_day_t easter9_r, carn9_r, gf9_r, asc9_r, whit9_r;

  always_comb begin
    easter_md = split_doy(easter8_r, leap8_r);
    carn_md   = split_doy(carn8_r, leap8_r);
    gf_md     = split_doy(gf8_r, leap8_r);
    asc_md    = split_doy(asc8_r, leap8_r);
    whit_md   = split_doy(whit8_r, leap8_r);
  end

  always_ff @(posedge clk) begin
    if (pc.en[9]) begin
      easter9_r <= easter_md;
      carn9_r   <= carn_md;
      gf9_r     <= gf_md;
      asc9_r    <= asc_md;
      whit9_r   <= whit_md;
    end
  end

  assign out_valid             = pc.vld[NUM_STAGES-1];
  assign out_easter_month      = easter9_r.month;
  assign out_easter_day        = easter9_r.day;
  assign out_carnival_month    = carn9_r.month[1:0];
  assign out_carnival_day      = carn9_r.day;
  assign out_good_friday_month = gf9_r.month;
  assign out_good_friday_day   = gf9_r.day;
  assign out_ascension_month   = asc9_r.month;
  assign out_ascension_day     = asc9_r.day;
  assign out_whitsun_month     = whit9_r.month;
  assign out_whitsun_day       = whit9_r.day;

endmodule
